/* rtl/tbms_pkg.sv */
// Shared types and constants for the triangular bit matrix store.
// Used by the front classifier, the request queue and the back end.
package tbms_pkg;

  // Widths fixed by the request fields.
  localparam int IDX_W      = 6;
  localparam int CMD_W      = 3;
  localparam int PROD_W     = 2 * IDX_W + 1;
  localparam int TRI_W      = 2 * IDX_W;
  localparam int BIT_SEL_W  = 3;
  localparam int BYTE_IDX_W = TRI_W - BIT_SEL_W;

  // Depth of the queue between front and back; a power of two.
  localparam int QDEPTH = 2;

  // Command codes as they arrive on the input.
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TSET   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TCLEAR = 3'd4;

  // What the back end does to the addressed bit.
  typedef enum logic [1:0] {
    OP_READ,
    OP_SET,
    OP_CLEAR
  } op_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic                  in_range;
    op_t                   op;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [BIT_SEL_W-1:0]  bit_sel;
  } entry_t;

endpackage

/* rtl/triangular_bit_matrix_store.sv */
// Packed symmetric bit matrix store, top level. Uses tbms_front, tbms_queue,
// tbms_back and tbms_pkg. The back end handles one item at a time: it reads
// the addressed byte in S_READ and writes it back in S_WRITE, and takes no new
// item until the last one is done. After reset the store is cleared one byte a
// cycle, all (MAX_ORDER*(MAX_ORDER+1)/2+7)/8 bytes (260 at the default), with
// in_full held high throughout.
module triangular_bit_matrix_store #(
  parameter int MAX_ORDER = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [tbms_pkg::CMD_W-1:0] in_command,
  input  logic [tbms_pkg::IDX_W-1:0] in_row,
  input  logic [tbms_pkg::IDX_W-1:0] in_col,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_old_bit
);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             clearing;
  tbms_pkg::entry_t q_entry;
  tbms_pkg::entry_t q_head;

  tbms_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .in_push    (in_push),
    .in_command (in_command),
    .in_row     (in_row),
    .in_col     (in_col),
    .q_full     (q_full),
    .clearing   (clearing),
    .in_full    (in_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  tbms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tbms_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_old_bit (out_old_bit)
  );

endmodule

/* rtl/tbms_front.sv */
// Front end: accepts items, orders row and column and computes the packed
// bit position and the operation. Depends on tbms_pkg.
module tbms_front #(
  parameter int MAX_ORDER = 64
) (
  input  logic                           in_push,
  input  logic [tbms_pkg::CMD_W-1:0]     in_command,
  input  logic [tbms_pkg::IDX_W-1:0]     in_row,
  input  logic [tbms_pkg::IDX_W-1:0]     in_col,
  input  logic                           q_full,
  input  logic                           clearing,
  output logic                           in_full,
  output logic                           q_push,
  output tbms_pkg::entry_t               q_entry
);

  logic [tbms_pkg::IDX_W-1:0]  hi;
  logic [tbms_pkg::IDX_W-1:0]  lo;
  logic [tbms_pkg::PROD_W-1:0] prod;
  logic [tbms_pkg::TRI_W-1:0]  tri_k;

  // Nothing is taken while the store is being cleared or the queue is full.
  assign in_full = q_full | clearing;
  assign q_push  = in_push & ~in_full;

  // Larger and smaller index, then hi*(hi+1)/2 + lo.
  always_comb begin
    if (in_row > in_col) begin
      hi = in_row;
      lo = in_col;
    end else begin
      hi = in_col;
      lo = in_row;
    end
    prod  = tbms_pkg::PROD_W'(hi) * (tbms_pkg::PROD_W'(hi) + tbms_pkg::PROD_W'(1));
    tri_k = tbms_pkg::TRI_W'(prod >> 1) + tbms_pkg::TRI_W'(lo);
  end

  // Classify the command; unused codes behave as a read.
  always_comb begin
    q_entry.in_range = (32'(hi) < MAX_ORDER);
    q_entry.byte_idx = tri_k[tbms_pkg::TRI_W-1:tbms_pkg::BIT_SEL_W];
    q_entry.bit_sel  = tri_k[tbms_pkg::BIT_SEL_W-1:0];
    case (in_command) inside
      tbms_pkg::CMD_SET, tbms_pkg::CMD_TSET: begin
        q_entry.op = tbms_pkg::OP_SET;
      end
      tbms_pkg::CMD_CLEAR, tbms_pkg::CMD_TCLEAR: begin
        q_entry.op = tbms_pkg::OP_CLEAR;
      end
      default: begin
        q_entry.op = tbms_pkg::OP_READ;
      end
    endcase
  end

endmodule

/* rtl/tbms_queue.sv */
// Short queue of classified items between the front and the back end.
// Depends on tbms_pkg for the entry type and the depth.
module tbms_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tbms_pkg::entry_t wr_entry,
  input  logic             pop,
  output tbms_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (tbms_pkg::QDEPTH > 1) ? $clog2(tbms_pkg::QDEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  tbms_pkg::entry_t entries_r [tbms_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(tbms_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

/* rtl/tbms_back.sv */
// Back end: clears the byte store after reset, then performs one
// read-modify-write per item and holds the result. Depends on tbms_pkg.
module tbms_back #(
  parameter int MAX_ORDER = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  tbms_pkg::entry_t q_head,
  output logic             q_pop,
  output logic             clearing,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_old_bit
);

  localparam int TRI_BITS    = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int STORE_BYTES = (TRI_BITS + 7) / 8;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READ,
    S_WRITE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_addr_r;
  tbms_pkg::entry_t op_r;
  logic             out_valid_r;
  logic             out_bit_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [STORE_BYTES];

  logic             take_out;
  logic             finish;
  logic             old_bit;
  logic [7:0]       mask;
  logic [7:0]       new_byte;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [7:0]       mem_wd;
  logic [AW-1:0]    mem_ra;

  assign clearing    = (state_r == S_CLEAR);
  assign out_empty   = ~out_valid_r;
  assign out_old_bit = out_bit_r;
  assign take_out    = out_pop & out_valid_r;

  // Issue a read when an item waits; finish once the result slot is free.
  always_comb begin
    q_pop  = (state_r == S_READ) && !q_empty;
    mem_ra = AW'(q_head.byte_idx);
    finish = (state_r == S_WRITE) && (!out_valid_r || take_out);
  end

  // Modify the fetched byte; out-of-range items report zero and write nothing.
  always_comb begin
    mask    = 8'h01 << op_r.bit_sel;
    old_bit = op_r.in_range & rd_data_r[op_r.bit_sel];
    case (op_r.op)
      tbms_pkg::OP_SET:   new_byte = rd_data_r | mask;
      tbms_pkg::OP_CLEAR: new_byte = rd_data_r & ~mask;
      default:            new_byte = rd_data_r;
    endcase
    mem_we = clearing ||
             (finish && op_r.in_range && (op_r.op != tbms_pkg::OP_READ));
    mem_wa = clearing ? clr_addr_r : AW'(op_r.byte_idx);
    mem_wd = clearing ? 8'h00 : new_byte;
  end

  // Byte store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Sequencer, clearing pass and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(STORE_BYTES - 1)) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (q_pop) begin
            op_r    <= q_head;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (finish) begin
            state_r <= S_READ;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
      if (finish) begin
        out_valid_r <= 1'b1;
        out_bit_r   <= old_bit;
      end else if (take_out) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/tbms_checker.sv */
// Port-level checks for the triangular bit matrix store, bound to its top
// level. Watches only the top-level handshake and result ports.
module tbms_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic out_old_bit
);

  // Items inside the block: two queued, one in the back end, one held result.
  localparam int PEND_MAX = 4;

  logic       acc_in;
  logic       acc_out;
  logic [2:0] pend_r;

  assign acc_in  = in_push & ~in_full;
  assign acc_out = out_pop & ~out_empty;

  // Count of items accepted whose results are not yet taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (acc_in && !acc_out) begin
      pend_r <= pend_r + 3'd1;
    end else if (acc_out && !acc_in) begin
      pend_r <= pend_r - 3'd1;
    end
  end

  // Reset starts the clearing pass, so nothing is accepted right after it.
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted straight after reset");

  // Reset empties the result side.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown straight after reset");

  // A result never appears without an item that caused it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (pend_r != 3'd0))
    else $error("result shown with no item outstanding");

  // The block never holds more items than its storage allows.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'(PEND_MAX))
    else $error("more items outstanding than the block can hold");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_old_bit)))
    else $error("waiting result changed or vanished");

endmodule

bind triangular_bit_matrix_store tbms_checker u_tbms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_push     (in_push),
  .in_full     (in_full),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_old_bit (out_old_bit)
);
